>>> sv/rc4sc_pkg.sv
// Shared types and constants for the RC4 cipher engine.
// No dependencies; imported by every module of the engine.
package rc4sc_pkg;

    // Permutation and key store geometry
    localparam int unsigned PERM_DEPTH = 256;
    localparam int unsigned ADDR_W     = 8;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CNT_W      = 9;

    // Key bytes kept; later key bytes are dropped
    localparam logic [CNT_W-1:0] MAX_KEY_BYTES = 9'd256;

    // Last index of the key scheduling sweep
    localparam logic [ADDR_W-1:0] LAST_IDX = 8'(PERM_DEPTH - 1);

    // Request codes
    localparam logic REQ_KEY  = 1'b0;
    localparam logic REQ_DATA = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [BYTE_W-1:0] byte_value;
        logic              key_last;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              no_key;
    } t_out_word;

    // Access to the permutation memory for one cycle
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [BYTE_W-1:0] wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } t_perm_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GEN1,
        ST_GEN2,
        ST_GEN3,
        ST_PEND,
        ST_KINIT,
        ST_K0,
        ST_K1,
        ST_K2,
        ST_KLAST
    } t_state;

endpackage

>>> sv/rc4sc_perm_mem.sv
// Permutation memory: 256 x 8, one write and one registered read per cycle.
// Per-entry valid bits make unwritten entries read as the identity.
// Depends on rc4sc_pkg.
module rc4sc_perm_mem import rc4sc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_perm_req         i_req,
    input  logic              i_clear,
    output logic [BYTE_W-1:0] o_rd_data
);

    logic [BYTE_W-1:0]     r_mem [PERM_DEPTH];
    logic [PERM_DEPTH-1:0] r_valid;
    logic [BYTE_W-1:0]     r_rd_mem;
    logic [ADDR_W-1:0]     r_rd_addr;
    logic                  r_rd_valid;
    logic                  r_fwd;
    logic [BYTE_W-1:0]     r_fwd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Track written entries; clear back to identity on demand
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= '0;
        end else if (i_req.wr_en) begin
            r_valid[i_req.wr_addr] <= 1'b1;
        end
    end

    // Registered read, capture a same-cycle write to the same entry
    always_ff @(posedge i_clk) begin
        r_rd_mem   <= r_mem[i_req.rd_addr];
        r_rd_addr  <= i_req.rd_addr;
        r_rd_valid <= r_valid[i_req.rd_addr];
        r_fwd      <= i_req.wr_en && (i_req.wr_addr == i_req.rd_addr);
        r_fwd_data <= i_req.wr_data;
    end

    assign o_rd_data = r_fwd      ? r_fwd_data :
                       r_rd_valid ? r_rd_mem   : r_rd_addr;

endmodule

>>> sv/rc4_stream_cipher_unit.sv
// Top level of the RC4 cipher engine: handshake, sequencer, key store.
// Depends on rc4sc_pkg and rc4sc_perm_mem.
//
// Channel  | Direction | Handshake               | Word
// ---------+-----------+-------------------------+------------------------------
// in       | input     | i_in_valid / o_in_stall | i_in_word  (t_in_word)
// out      | output    | o_out_valid/ i_out_stall| o_out_word (t_out_word)
//
// A data word uses the single permutation memory in these steps: read S[i],
// read S[j], write S[i] and read S[S[i]+S[j]], write S[j]; the next word can
// be taken during the write of S[j] while the output is free.
// A key word that is not the last leaves the engine idle. The last key word
// starts scheduling: clear the permutation, then read S[k], read S[acc] and
// write S[k] for each of 256 entries, then a final write; no word is accepted.
// Reset is synchronous and active low; the permutation reads as identity.
// A result waiting on a stalled output is parked; input stalls until it leaves.
module rc4_stream_cipher_unit import rc4sc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_state            r_state, n_state;
    t_perm_req         w_req;
    logic              w_clear;
    logic [BYTE_W-1:0] w_rd;

    logic              w_out_free;
    logic              w_can_take;
    logic              w_in_take;
    logic              w_take_data;
    logic              w_take_key;
    logic              w_key_room;

    // Generator state
    logic [ADDR_W-1:0] r_i, r_j, r_si, r_idx;
    logic [BYTE_W-1:0] r_val;
    logic              r_nokey;
    logic              r_keyed;
    logic [ADDR_W-1:0] w_j_new, w_idx_new;
    logic [BYTE_W-1:0] w_ks;
    t_out_word         w_res;

    // Key store and scheduling state
    logic [BYTE_W-1:0] r_key_mem [PERM_DEPTH];
    logic [BYTE_W-1:0] r_key_rd;
    logic [CNT_W-1:0]  r_key_count;
    logic [CNT_W-1:0]  w_key_len;
    logic [ADDR_W-1:0] r_k, r_acc, r_kidx;
    logic [ADDR_W-1:0] w_mix_new, w_kidx_next;
    logic [CNT_W-1:0]  w_kidx_inc;

    // Output register and parked result
    logic              r_out_valid;
    t_out_word         r_out_word;
    t_out_word         r_pend;

    rc4sc_perm_mem u_perm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .i_clear   (w_clear),
        .o_rd_data (w_rd)
    );

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_in_take   = i_in_valid && w_can_take;
    assign w_take_data = w_in_take && (i_in_word.req_type == REQ_DATA);
    assign w_take_key  = w_in_take && (i_in_word.req_type == REQ_KEY);
    assign w_key_room  = r_key_count < MAX_KEY_BYTES;

    // Generator arithmetic
    assign w_j_new   = r_j + w_rd;
    assign w_idx_new = r_si + w_rd;
    // S[j] is still old in memory; after the swap it holds S[i]
    assign w_ks      = (r_idx == r_j) ? r_si : w_rd;
    assign w_res.out_byte = r_val ^ w_ks;
    assign w_res.no_key   = r_nokey;

    // Key scheduling arithmetic
    assign w_key_len   = (r_key_count == '0) ? CNT_W'(1) : r_key_count;
    assign w_mix_new   = r_acc + w_rd + r_key_rd;
    assign w_kidx_inc  = {1'b0, r_kidx} + CNT_W'(1);
    assign w_kidx_next = (w_kidx_inc >= w_key_len) ? '0 : w_kidx_inc[ADDR_W-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            ST_IDLE, ST_GEN3, ST_PEND: begin
                if (w_take_data) begin
                    n_state = ST_GEN1;
                end else if (w_take_key) begin
                    n_state = i_in_word.key_last ? ST_KINIT : ST_IDLE;
                end else if (r_state == ST_IDLE) begin
                    n_state = ST_IDLE;
                end else if (w_out_free) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_PEND;
                end
            end
            ST_GEN1:  n_state = ST_GEN2;
            ST_GEN2:  n_state = ST_GEN3;
            ST_KINIT: n_state = ST_K0;
            ST_K0:    n_state = ST_K1;
            ST_K1:    n_state = ST_K2;
            ST_K2:    n_state = (r_k == LAST_IDX) ? ST_KLAST : ST_K0;
            ST_KLAST: n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Memory accesses and input stall per state
    always_comb begin
        w_can_take = 1'b0;
        w_clear    = 1'b0;
        w_req      = '0;
        unique case (r_state)
            ST_IDLE: begin
                w_can_take = 1'b1;
            end
            ST_GEN1: begin
                w_req.rd_addr = w_j_new;
            end
            ST_GEN2: begin
                w_req.wr_en   = 1'b1;
                w_req.wr_addr = r_i;
                w_req.wr_data = w_rd;
                w_req.rd_addr = w_idx_new;
            end
            ST_GEN3: begin
                w_req.wr_en   = 1'b1;
                w_req.wr_addr = r_j;
                w_req.wr_data = r_si;
                w_can_take    = w_out_free;
            end
            ST_PEND: begin
                w_can_take = w_out_free;
            end
            ST_KINIT: begin
                w_clear = 1'b1;
            end
            ST_K0: begin
                // finish the previous entry's swap
                w_req.wr_en   = (r_k != '0);
                w_req.wr_addr = r_acc;
                w_req.wr_data = r_si;
                w_req.rd_addr = r_k;
            end
            ST_K1: begin
                w_req.rd_addr = w_mix_new;
            end
            ST_K2: begin
                w_req.wr_en   = 1'b1;
                w_req.wr_addr = r_k;
                w_req.wr_data = w_rd;
            end
            ST_KLAST: begin
                w_req.wr_en   = 1'b1;
                w_req.wr_addr = r_acc;
                w_req.wr_data = r_si;
            end
            default: begin
                w_can_take = 1'b0;
            end
        endcase
        // start a data word: read S[i+1]
        if (w_take_data) begin
            w_req.rd_addr = r_i + ADDR_W'(1);
        end
    end

    assign o_in_stall = !w_can_take;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_i         <= '0;
            r_j         <= '0;
            r_key_count <= '0;
            r_keyed     <= 1'b0;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_kidx      <= '0;
        end else begin
            r_state <= n_state;
            if (w_take_data) begin
                r_i <= r_i + ADDR_W'(1);
            end
            if (w_take_key && w_key_room) begin
                r_key_count <= r_key_count + CNT_W'(1);
            end
            if (r_state == ST_GEN1) begin
                r_j <= w_j_new;
            end
            if (r_state == ST_KINIT) begin
                r_k    <= '0;
                r_kidx <= '0;
            end
            if (r_state == ST_K1) begin
                r_kidx <= w_kidx_next;
            end
            if (r_state == ST_K2) begin
                r_k <= r_k + ADDR_W'(1);
            end
            if (r_state == ST_KLAST) begin
                r_i         <= '0;
                r_j         <= '0;
                r_key_count <= '0;
                r_keyed     <= 1'b1;
            end
            if (w_out_free) begin
                r_out_valid <= (r_state == ST_GEN3) || (r_state == ST_PEND);
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (w_take_data) begin
            r_val   <= i_in_word.byte_value;
            r_nokey <= !r_keyed;
        end
        if (r_state == ST_GEN1 || r_state == ST_K1) begin
            r_si <= w_rd;
        end
        if (r_state == ST_GEN2) begin
            r_idx <= w_idx_new;
        end
        if (r_state == ST_KINIT) begin
            r_acc <= '0;
        end
        if (r_state == ST_K1) begin
            r_acc <= w_mix_new;
        end
        // load the output, or park the result while the output is held
        if (w_out_free) begin
            if (r_state == ST_GEN3) begin
                r_out_word <= w_res;
            end else if (r_state == ST_PEND) begin
                r_out_word <= r_pend;
            end
        end else if (r_state == ST_GEN3) begin
            r_pend <= w_res;
        end
    end

    // Key store: write on key words, read during scheduling
    always_ff @(posedge i_clk) begin
        if (w_take_key && w_key_room) begin
            r_key_mem[r_key_count[ADDR_W-1:0]] <= i_in_word.byte_value;
        end
        r_key_rd <= r_key_mem[r_kidx];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

>>> sv/rc4sc_checker.sv
// Port-level checks for the RC4 cipher engine, bound to the top level.
// Depends on rc4sc_pkg and rc4_stream_cipher_unit.
module rc4sc_checker import rc4sc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_word,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // Hold a stalled result word
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_word))
        else $error("output word changed while stalled");

    // The input stalls while a data word occupies the memory
    a_data_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_word.req_type == REQ_DATA)
        |=> o_in_stall ##1 o_in_stall)
        else $error("input taken while a data word is in flight");

    // The last key word starts scheduling, which blocks input
    a_sched_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_word.req_type == REQ_KEY)
        && i_in_word.key_last |=> o_in_stall ##1 o_in_stall ##1 o_in_stall)
        else $error("input taken during key scheduling");

endmodule

bind rc4_stream_cipher_unit rc4sc_checker u_rc4sc_checker (.*);

>>> verif/tb_rc4_stream_cipher_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for rc4_stream_cipher_unit: key loading, key scheduling, data.
// Depends on rc4sc_pkg and the engine RTL; predicts every output word in SystemVerilog.
module tb_rc4_stream_cipher_unit;
    import rc4sc_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int GAP_MAX       = 14;
    // Long enough for a scheduling pass to finish
    localparam int SCHED_CYCLES  = 800;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int RANDOM_WORDS  = 280;
    localparam int REPORT_MAX    = 10;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_word  i_in_word;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_word o_out_word;

    // Cipher state mirror
    logic [7:0]  perm_state [256];
    logic [7:0]  key_bytes [256];
    int unsigned key_len;
    logic [7:0]  ctr_i;
    logic [7:0]  ctr_j;
    logic        have_key;

    t_out_word   cipher_out_q [$];

    int send_gap_max;
    int recv_stall_max;
    int hold_left;
    int words_sent;
    int fail_count;
    int cycle_count;

    rc4_stream_cipher_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    initial begin : clk_gen
        i_clk = 1'b0;
        forever begin
            #CLK_HALF i_clk = ~i_clk;
        end
    end

    // End the run if the engine hangs
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("rc4_stream_cipher_unit regression: fail");
        $finish;
    end

    // Advance the mirror by one accepted word; queue the cipher byte of a data word
    function automatic void apply_rc4_word(input t_in_word w);
        logic [7:0]  acc;
        logic [7:0]  tmp;
        logic [7:0]  idx;
        int unsigned len;
        t_out_word   r;
        if (w.req_type == REQ_KEY) begin
            // Drop key bytes once the store is full
            if (key_len < MAX_KEY_BYTES) begin
                key_bytes[key_len] = w.byte_value;
                key_len++;
            end
            if (w.key_last) begin
                len = (key_len == 0) ? 1 : key_len;
                for (int k = 0; k < 256; k++) begin
                    perm_state[k] = 8'(k);
                end
                acc = 8'h00;
                for (int k = 0; k < 256; k++) begin
                    acc = acc + perm_state[k] + key_bytes[k % len];
                    tmp = perm_state[k];
                    perm_state[k] = perm_state[acc];
                    perm_state[acc] = tmp;
                end
                ctr_i    = 8'h00;
                ctr_j    = 8'h00;
                key_len  = 0;
                have_key = 1'b1;
            end
        end else begin
            ctr_i = ctr_i + 8'd1;
            ctr_j = ctr_j + perm_state[ctr_i];
            tmp = perm_state[ctr_i];
            perm_state[ctr_i] = perm_state[ctr_j];
            perm_state[ctr_j] = tmp;
            idx = perm_state[ctr_i] + perm_state[ctr_j];
            r.out_byte = w.byte_value ^ perm_state[idx];
            r.no_key   = ~have_key;
            cipher_out_q = {cipher_out_q, r};
        end
    endfunction

    // Offer one word after a random gap and hold it until taken
    task automatic send_word(input logic req, input logic [7:0] val, input logic last);
        int       gap;
        t_in_word w;
        gap = $urandom_range(0, send_gap_max);
        w.req_type   = req;
        w.byte_value = val;
        w.key_last   = last;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do begin
            @(posedge i_clk);
        end while (!(i_in_valid && !o_in_stall));
        apply_rc4_word(w);
        words_sent++;
    endtask

    task automatic send_key(input int len, input logic with_last);
        for (int k = 0; k < len; k++) begin
            send_word(REQ_KEY, 8'($urandom), with_last && (k == len - 1));
        end
    endtask

    task automatic send_data(input int n);
        for (int k = 0; k < n; k++) begin
            send_word(REQ_DATA, 8'($urandom), 1'($urandom));
        end
    endtask

    // Receiver: draw a stall after each taken word, honor long hold-offs
    initial begin : out_side
        int stall_left;
        stall_left = 0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                stall_left = $urandom_range(0, recv_stall_max);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    // Compare each taken word with the oldest prediction
    always @(posedge i_clk) begin : out_check
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cipher_out_q.size() == 0) begin
                if (fail_count < REPORT_MAX) begin
                    $display("unexpected word: out_byte=%02h no_key=%0b",
                             o_out_word.out_byte, o_out_word.no_key);
                end
                fail_count++;
            end else begin
                want = cipher_out_q.pop_front();
                if (o_out_word.out_byte !== want.out_byte ||
                    o_out_word.no_key !== want.no_key) begin
                    if (fail_count < REPORT_MAX) begin
                        $display("mismatch: out_byte exp %02h got %02h, no_key exp %0b got %0b",
                                 want.out_byte, o_out_word.out_byte,
                                 want.no_key, o_out_word.no_key);
                    end
                    fail_count++;
                end
            end
        end
    end

    // Data before any key runs on the identity permutation, flagged
    task automatic test_data_before_key();
        send_word(REQ_DATA, 8'h00, 1'b0);
        send_word(REQ_DATA, 8'hFF, 1'b1);
        send_word(REQ_DATA, 8'h5A, 1'b0);
    endtask

    // One-byte keys at both extremes, then a short multi-byte key
    task automatic test_short_keys();
        send_word(REQ_KEY, 8'h00, 1'b1);
        send_word(REQ_DATA, 8'h00, 1'b0);
        send_word(REQ_DATA, 8'hFF, 1'b0);
        send_word(REQ_KEY, 8'hFF, 1'b1);
        send_word(REQ_DATA, 8'hFF, 1'b1);
        send_word(REQ_DATA, 8'h00, 1'b0);
        send_word(REQ_KEY, 8'h4B, 1'b0);
        send_word(REQ_KEY, 8'h65, 1'b0);
        send_word(REQ_KEY, 8'h79, 1'b1);
        send_data(4);
    endtask

    // Data mixed into a key load uses the old permutation and counters
    task automatic test_data_during_key_load();
        send_word(REQ_KEY, 8'h11, 1'b0);
        send_word(REQ_DATA, 8'hA5, 1'b0);
        send_word(REQ_KEY, 8'h22, 1'b0);
        send_word(REQ_DATA, 8'h3C, 1'b1);
        send_word(REQ_KEY, 8'h33, 1'b1);
        send_data(2);
    endtask

    // Overfull key: extra bytes dropped, the dropped last byte still schedules
    task automatic test_key_overflow();
        send_key(257, 1'b1);
        send_data(3);
    endtask

    // Hold the receiver off long enough that the engine stalls its input
    task automatic test_output_backpressure();
        send_gap_max   = 0;
        recv_stall_max = 0;
        hold_left      = 300;
        send_data(24);
        send_gap_max   = GAP_MAX;
        recv_stall_max = GAP_MAX;
    endtask

    // Mostly keyed sessions with random content, some broken or noisy ones
    task automatic test_random_traffic();
        int stop_at;
        int pick;
        int len;
        stop_at = words_sent + RANDOM_WORDS;
        while (words_sent < stop_at) begin
            send_gap_max   = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            recv_stall_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            pick = $urandom_range(0, 9);
            len  = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 64)
                                                : $urandom_range(1, 16);
            if (pick <= 6) begin
                send_key(len, 1'b1);
                send_data($urandom_range(1, 40));
            end else if (pick == 7) begin
                send_data($urandom_range(1, 20));
            end else if (pick == 8) begin
                // Key load broken up by data words
                send_key($urandom_range(1, 4), 1'b0);
                send_data($urandom_range(1, 5));
                send_key($urandom_range(1, 4), 1'b1);
                send_data($urandom_range(1, 10));
            end else begin
                // Unfinished key; later bytes extend it
                send_key($urandom_range(1, 6), 1'b0);
                send_data($urandom_range(0, 6));
            end
        end
    endtask

    initial begin : main
        for (int k = 0; k < 256; k++) begin
            perm_state[k] = 8'(k);
            key_bytes[k]  = 8'h00;
        end
        key_len        = 0;
        ctr_i          = 8'h00;
        ctr_j          = 8'h00;
        have_key       = 1'b0;
        send_gap_max   = GAP_MAX;
        recv_stall_max = GAP_MAX;
        hold_left      = 0;
        words_sent     = 0;
        fail_count     = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_data_before_key();
        test_short_keys();
        test_data_during_key_load();
        test_key_overflow();
        test_output_backpressure();
        test_random_traffic();

        // Drain, then let any scheduling pass run out
        i_in_valid <= 1'b0;
        while (cipher_out_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SCHED_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && cipher_out_q.size() == 0) begin
            $display("rc4_stream_cipher_unit regression: pass");
        end else begin
            $display("rc4_stream_cipher_unit regression: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/rc4sc_pkg.sv
sv/rc4sc_perm_mem.sv
sv/rc4_stream_cipher_unit.sv
sv/rc4sc_checker.sv
verif/tb_rc4_stream_cipher_unit.sv
